>>> src/dpb_pkg.sv
// ----------------------------------------------------------------------------
// dpb_pkg
// Shared types, register codes and constants of the depth back-projection core.
// ----------------------------------------------------------------------------
package dpb_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int DEPTH_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int ZW         = 24;
  localparam int INV_W      = 24;
  localparam int CENTER_W   = 16;
  localparam int SPLIT      = 12;
  localparam int PT_W       = 32;
  localparam int COLOR_W    = 8;

  localparam logic [15:0] NEAR_Z = 16'd32768;

  localparam logic [23:0] RST_INV_DEPTH_SCALE = 24'd3355;
  localparam logic [23:0] RST_MAX_DEPTH       = 24'd327680;
  localparam logic [15:0] RST_CENTER_X        = 16'd5112;
  localparam logic [15:0] RST_CENTER_Y        = 16'd3832;
  localparam logic [23:0] RST_INV_FOCAL_X     = 24'd31957;
  localparam logic [23:0] RST_INV_FOCAL_Y     = 24'd31957;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_DEPTH_SCALE = 3'd0,
    CFG_MAX_DEPTH       = 3'd1,
    CFG_CENTER_X        = 3'd2,
    CFG_CENTER_Y        = 3'd3,
    CFG_INV_FOCAL_X     = 3'd4,
    CFG_INV_FOCAL_Y     = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [23:0] inv_depth_scale;
    logic [23:0] max_depth;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [23:0] inv_focal_x;
    logic [23:0] inv_focal_y;
  } cfg_t;

  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en4;
  } pipe_en_t;

endpackage

>>> src/dpb_if.sv
// ----------------------------------------------------------------------------
// dpb_if
// Valid/ready channels for depth pixels in and camera-frame points out.
// ----------------------------------------------------------------------------
interface dpb_pixel_if #(
  parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF,
  parameter int DEPTH_BITS = dpb_pkg::DEPTH_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_col;
  logic [COORD_BITS-1:0] pixel_row;
  logic [DEPTH_BITS-1:0] depth_raw;
  logic [7:0]            blue_in;
  logic [7:0]            green_in;
  logic [7:0]            red_in;

  modport source(output valid, pixel_col, pixel_row, depth_raw, blue_in, green_in, red_in,
                 input ready);
  modport sink(input valid, pixel_col, pixel_row, depth_raw, blue_in, green_in, red_in,
               output ready);
endinterface

interface dpb_point_if;
  logic        valid;
  logic        ready;
  logic [31:0] point_x;
  logic [31:0] point_y;
  logic [23:0] point_z;
  logic [7:0]  blue_out;
  logic [7:0]  green_out;
  logic [7:0]  red_out;

  modport source(output valid, point_x, point_y, point_z, blue_out, green_out, red_out,
                 input ready);
  modport sink(input valid, point_x, point_y, point_z, blue_out, green_out, red_out,
               output ready);
endinterface

>>> src/depth_pixel_backprojection_core.sv
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_core
// Back-projects depth pixels through a pinhole camera into camera-frame points.
//
//   channel  dir  handshake      payload
//   in_pix   in   valid/ready    pixel_col, pixel_row, depth_raw, blue/green/red_in
//   out_pt   out  valid/ready    point_x, point_y, point_z, blue/green/red_out
//   cfg      in   cfg_we         cfg_index, cfg_data
//
// One item is accepted per cycle while in_pix.ready is high; a kept point
// passes the four register stages of the projection multiply to the output.
// Each stage holds while the one after it is full and stalled.
// Dropped items leave a bubble and never reach the output.
// Reset restores the register defaults and empties the pipeline.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection_core #(
  parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF,
  parameter int DEPTH_BITS = dpb_pkg::DEPTH_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  dpb_pixel_if.sink                      in_pix,
  dpb_point_if.source                    out_pt,
  input  logic                           cfg_we,
  input  logic [dpb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dpb_pkg::*;

  localparam int PROD_W = DEPTH_BITS + 24;
  localparam int ZF_W   = DEPTH_BITS + 16;

  cfg_t     cfg;
  pipe_en_t en;

  logic v1_r, v2_r, v3_r, v4_r;
  logic v2_nxt;
  logic rdy1, rdy2, rdy3, rdy4;

  logic [PROD_W-1:0]  prod;
  logic [ZF_W-1:0]    zf1_r;
  logic [ZW-1:0]      z2_r, z3_r, z4_r;
  logic [3*COLOR_W-1:0] c1_r, c2_r, c3_r, c4_r;

  dpb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign rdy4 = !v4_r || out_pt.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign en.en1 = rdy1;
  assign en.en2 = rdy2;
  assign en.en3 = rdy3;
  assign en.en4 = rdy4;

  assign in_pix.ready = rdy1;

  assign prod   = PROD_W'(in_pix.depth_raw) * PROD_W'(cfg.inv_depth_scale);
  assign v2_nxt = v1_r && (zf1_r >= ZF_W'(NEAR_Z)) && (zf1_r <= ZF_W'(cfg.max_depth));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en.en1) v1_r <= in_pix.valid;
      if (en.en2) v2_r <= v2_nxt;
      if (en.en3) v3_r <= v2_r;
      if (en.en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en.en1) begin
      zf1_r <= prod[PROD_W-1:8];
      c1_r  <= {in_pix.blue_in, in_pix.green_in, in_pix.red_in};
    end
    if (en.en2) begin
      z2_r <= zf1_r[ZW-1:0];
      c2_r <= c1_r;
    end
    if (en.en3) begin
      z3_r <= z2_r;
      c3_r <= c2_r;
    end
    if (en.en4) begin
      z4_r <= z3_r;
      c4_r <= c3_r;
    end
  end

  dpb_project_lane #(.COORD_BITS(COORD_BITS)) u_lane_x (
    .clk    (clk),
    .en     (en),
    .coord  (in_pix.pixel_col),
    .center (cfg.center_x),
    .z1     (zf1_r[ZW-1:0]),
    .inv    (cfg.inv_focal_x),
    .point  (out_pt.point_x)
  );

  dpb_project_lane #(.COORD_BITS(COORD_BITS)) u_lane_y (
    .clk    (clk),
    .en     (en),
    .coord  (in_pix.pixel_row),
    .center (cfg.center_y),
    .z1     (zf1_r[ZW-1:0]),
    .inv    (cfg.inv_focal_y),
    .point  (out_pt.point_y)
  );

  assign out_pt.valid     = v4_r;
  assign out_pt.point_z   = z4_r;
  assign out_pt.blue_out  = c4_r[3*COLOR_W-1:2*COLOR_W];
  assign out_pt.green_out = c4_r[2*COLOR_W-1:COLOR_W];
  assign out_pt.red_out   = c4_r[COLOR_W-1:0];

  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_pt.ready |-> in_pix.ready)
    else $error("input stalled while the output side is ready");

  a_near_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_pt.valid |-> (out_pt.point_z >= ZW'(NEAR_Z)))
    else $error("point nearer than the near limit delivered");

  a_stage2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !en.en2) |=> (v2_r && $stable(z2_r)))
    else $error("stalled stage two item lost or changed");

endmodule

>>> src/dpb_cfg_regs.sv
// ----------------------------------------------------------------------------
// dpb_cfg_regs
// Camera and depth configuration registers with a plain write port.
// ----------------------------------------------------------------------------
module dpb_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dpb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpb_pkg::CFG_DATA_W-1:0] cfg_data,
  output dpb_pkg::cfg_t                  cfg
);
  import dpb_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_INV_DEPTH_SCALE: cfg_nxt.inv_depth_scale = cfg_data;
        CFG_MAX_DEPTH:       cfg_nxt.max_depth       = cfg_data;
        CFG_CENTER_X:        cfg_nxt.center_x        = cfg_data[15:0];
        CFG_CENTER_Y:        cfg_nxt.center_y        = cfg_data[15:0];
        CFG_INV_FOCAL_X:     cfg_nxt.inv_focal_x     = cfg_data;
        CFG_INV_FOCAL_Y:     cfg_nxt.inv_focal_y     = cfg_data;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inv_depth_scale <= RST_INV_DEPTH_SCALE;
      cfg_r.max_depth       <= RST_MAX_DEPTH;
      cfg_r.center_x        <= RST_CENTER_X;
      cfg_r.center_y        <= RST_CENTER_Y;
      cfg_r.inv_focal_x     <= RST_INV_FOCAL_X;
      cfg_r.inv_focal_y     <= RST_INV_FOCAL_Y;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> src/dpb_project_lane.sv
// ----------------------------------------------------------------------------
// dpb_project_lane
// Four-stage lateral projection: offset, offset times depth, split product
// with the focal reciprocal, then truncation and signed saturation.
// ----------------------------------------------------------------------------
module dpb_project_lane #(
  parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  dpb_pkg::pipe_en_t            en,
  input  logic [COORD_BITS-1:0]        coord,
  input  logic [dpb_pkg::CENTER_W-1:0] center,
  input  logic [dpb_pkg::ZW-1:0]       z1,
  input  logic [dpb_pkg::INV_W-1:0]    inv,
  output logic [dpb_pkg::PT_W-1:0]     point
);
  import dpb_pkg::*;

  localparam int POS_W  = COORD_BITS + 4;
  localparam int MAG_W  = (POS_W > CENTER_W) ? POS_W : CENTER_W;
  localparam int DIFF_W = MAG_W + 1;
  localparam int MZ_W   = MAG_W + ZW;
  localparam int HI_W   = MZ_W + SPLIT;
  localparam int SUM_W  = HI_W + 1;
  localparam int Q_W    = SUM_W - 16;

  logic [DIFF_W-1:0] diff;
  logic [MAG_W-1:0]  mag_nxt;
  logic [MAG_W-1:0]  mag_r;
  logic              neg1_r;
  logic [MZ_W-1:0]   mz_r;
  logic              neg2_r;
  logic [HI_W-1:0]   hi_r;
  logic [HI_W-1:0]   lo_r;
  logic              neg3_r;
  logic [SUM_W-1:0]  sum;
  logic [Q_W-1:0]    q;
  logic              big;
  logic [PT_W-1:0]   point_nxt;
  logic [PT_W-1:0]   point_r;

  assign diff    = DIFF_W'({coord, 4'b0000}) - DIFF_W'(center);
  assign mag_nxt = diff[DIFF_W-1] ? MAG_W'(-diff) : diff[MAG_W-1:0];

  assign sum = SUM_W'(hi_r) + SUM_W'(lo_r[HI_W-1:SPLIT]);
  assign q   = sum[SUM_W-1:16];
  assign big = |q[Q_W-1:PT_W-1];

  always_comb begin
    if (neg3_r) begin
      point_nxt = big ? 32'h8000_0000 : (32'd0 - q[PT_W-1:0]);
    end else begin
      point_nxt = big ? 32'h7FFF_FFFF : q[PT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.en1) begin
      mag_r  <= mag_nxt;
      neg1_r <= diff[DIFF_W-1];
    end
    if (en.en2) begin
      mz_r   <= MZ_W'(mag_r) * MZ_W'(z1);
      neg2_r <= neg1_r;
    end
    if (en.en3) begin
      hi_r   <= HI_W'(mz_r) * HI_W'(inv[INV_W-1:SPLIT]);
      lo_r   <= HI_W'(mz_r) * HI_W'(inv[SPLIT-1:0]);
      neg3_r <= neg2_r;
    end
    if (en.en4) begin
      point_r <= point_nxt;
    end
  end

  assign point = point_r;

endmodule
